// ----- src/sdt_pkg.sv -----
`timescale 1ns / 1ps
package sdt_pkg;

    localparam int TABLE_NUM = 12;
    localparam int NOTE_W    = 7;
    localparam int SHIFT_W   = 6;
    localparam int OUT_W     = 9;
    localparam int TYPE_W    = 4;
    localparam int OCT_W     = 6;

    // configuration register indexes
    localparam logic CFG_ROOT  = 1'b0;
    localparam logic CFG_SCALE = 1'b1;

    typedef logic [3:0] t_pc;
    typedef logic [2:0] t_deg;
    typedef logic [TYPE_W-1:0] t_sel;

    // interval rows, one nibble per degree, degree 0 in the low nibble
    localparam logic [31:0] SCALE_ROWS [TABLE_NUM] = '{
        32'h0B975420,   // major
        32'h0A875320,   // natural minor
        32'h0B875320,   // harmonic minor
        32'h0B975320,   // melodic minor
        32'h0A975320,   // dorian
        32'h0A875310,   // phrygian
        32'h0B976420,   // lydian
        32'h0A975420,   // mixolydian
        32'h0A865310,   // locrian
        32'h00097420,   // major pentatonic
        32'h000A7530,   // minor pentatonic
        32'h00A76530    // blues minor
    };

    localparam logic [2:0] SCALE_LEN [TABLE_NUM] = '{
        3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd5, 3'd5, 3'd6
    };

    // located item: octave and snapped degree, plus what later stages need
    typedef struct packed {
        logic signed [OCT_W-1:0]   octave;
        t_deg                      degree;
        logic signed [SHIFT_W-1:0] shift;
        t_pc                       root;
        t_sel                      sel;
    } t_loc;

    // wrapped item: final octave and table index
    typedef struct packed {
        logic signed [OCT_W-1:0] octave;
        t_deg                    idx;
        t_pc                     root;
        t_sel                    sel;
    } t_wrap;

    function automatic t_pc scale_iv(input t_sel sel, input t_deg idx);
        logic [31:0] row;
        row = SCALE_ROWS[sel];
        return row[{idx, 2'b00} +: 4];
    endfunction

    function automatic t_pc absdiff(input t_pc a, input t_pc b);
        return (a > b) ? a - b : b - a;
    endfunction

    // floor(x / 12) by reciprocal, exact over the whole 8-bit range of x
    function automatic logic [4:0] div12(input logic [7:0] x);
        logic [15:0] prod;
        prod = 16'(x) * 16'd171;
        return prod[15:11];
    endfunction

endpackage

// ----- src/sdt_cfg.sv -----
`timescale 1ns / 1ps
module sdt_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [sdt_pkg::NOTE_W-1:0]  i_cfg_data,
    output sdt_pkg::t_pc                o_root,
    output sdt_pkg::t_sel               o_sel
);

    sdt_pkg::t_pc  r_root;
    sdt_pkg::t_sel r_sel;
    logic [4:0]    quo;
    logic [7:0]    rem;

    // root kept as its pitch class
    always_comb begin
        quo = sdt_pkg::div12({1'b0, i_cfg_data});
        rem = {1'b0, i_cfg_data} - 8'({3'b0, quo}) * 8'd12;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root <= '0;
            r_sel  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sdt_pkg::CFG_ROOT: begin
                    r_root <= rem[3:0];
                end
                sdt_pkg::CFG_SCALE: begin
                    // unknown scale codes fall back to major
                    r_sel <= (i_cfg_data[3:0] >= 4'(sdt_pkg::TABLE_NUM)) ? '0
                                                                       : i_cfg_data[3:0];
                end
                default: begin
                    r_root <= r_root;
                end
            endcase
        end
    end

    assign o_root = r_root;
    assign o_sel  = r_sel;

endmodule

// ----- src/sdt_locate.sv -----
`timescale 1ns / 1ps
module sdt_locate (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic [sdt_pkg::NOTE_W-1:0]        i_note,
    input  logic signed [sdt_pkg::SHIFT_W-1:0] i_shift,
    input  sdt_pkg::t_pc                      i_root,
    input  sdt_pkg::t_sel                     i_sel,
    output logic                              o_valid,
    output sdt_pkg::t_loc                     o_loc
);

    typedef struct packed {
        logic signed [sdt_pkg::OCT_W-1:0]   octave;
        sdt_pkg::t_pc                       rel;
        logic signed [sdt_pkg::SHIFT_W-1:0] shift;
        sdt_pkg::t_pc                       root;
        sdt_pkg::t_sel                      sel;
    } t_split;

    logic          r_a_valid;
    t_split        r_a;
    t_split        n_a;
    logic          r_b_valid;
    sdt_pkg::t_loc r_b;
    sdt_pkg::t_loc n_b;

    logic [7:0]    pos;
    logic [4:0]    quo;
    logic [7:0]    rem;
    logic [2:0]    len;
    sdt_pkg::t_deg best_deg;
    sdt_pkg::t_pc  best_dist;
    sdt_pkg::t_pc  cur_gap;

    // stage a: floor split into octave and pitch class relative to root
    always_comb begin
        pos = {1'b0, i_note} + 8'd12 - {4'b0, i_root};
        quo = sdt_pkg::div12(pos);
        rem = pos - 8'({3'b0, quo}) * 8'd12;
        n_a.octave = $signed(6'({1'b0, quo}) - 6'd1);
        n_a.rel    = rem[3:0];
        n_a.shift  = i_shift;
        n_a.root   = i_root;
        n_a.sel    = i_sel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a <= n_a;
    end

    // stage b: nearest table degree, ties keep the lower index
    always_comb begin
        len       = sdt_pkg::SCALE_LEN[r_a.sel];
        best_deg  = '0;
        best_dist = sdt_pkg::absdiff(sdt_pkg::scale_iv(r_a.sel, 3'd0), r_a.rel);
        for (int i = 1; i < 7; i++) begin
            cur_gap = sdt_pkg::absdiff(sdt_pkg::scale_iv(r_a.sel, 3'(i)), r_a.rel);
            if (3'(i) < len && cur_gap < best_dist) begin
                best_deg  = 3'(i);
                best_dist = cur_gap;
            end
        end
        n_b.octave = r_a.octave;
        n_b.degree = best_deg;
        n_b.shift  = r_a.shift;
        n_b.root   = r_a.root;
        n_b.sel    = r_a.sel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b <= n_b;
    end

    assign o_valid = r_b_valid;
    assign o_loc   = r_b;

`ifndef SYNTHESIS
    a_rel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid |-> r_a.rel < 4'd12)
        else $error("pitch class out of range");

    a_degree_in_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid |-> r_b.degree < sdt_pkg::SCALE_LEN[r_b.sel])
        else $error("snapped degree beyond scale length");
`endif

endmodule

// ----- src/sdt_wrap.sv -----
`timescale 1ns / 1ps
module sdt_wrap (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  sdt_pkg::t_loc  i_loc,
    output logic           o_valid,
    output sdt_pkg::t_wrap o_wrap
);

    typedef struct packed {
        logic [6:0]                       total;
        logic [4:0]                       quo;
        logic [2:0]                       len;
        logic signed [sdt_pkg::OCT_W-1:0] octave;
        sdt_pkg::t_pc                     root;
        sdt_pkg::t_sel                    sel;
    } t_div;

    logic           r_c_valid;
    t_div           r_c;
    t_div           n_c;
    logic           r_d_valid;
    sdt_pkg::t_wrap r_d;
    sdt_pkg::t_wrap n_d;

    logic [2:0]  len;
    logic [7:0]  sum;
    logic [7:0]  recip;
    logic [14:0] prod;
    logic [6:0]  rem;

    // stage c: degree sum biased by 8 scale lengths so it stays positive
    always_comb begin
        len = sdt_pkg::SCALE_LEN[i_loc.sel];
        sum = {5'b0, i_loc.degree} + {{2{i_loc.shift[5]}}, i_loc.shift}
            + {2'b0, len, 3'b000};
        case (len)
            3'd5:    recip = 8'd205;
            3'd6:    recip = 8'd171;
            default: recip = 8'd147;
        endcase
        prod = 15'(sum[6:0]) * 15'(recip);
        n_c.total  = sum[6:0];
        n_c.quo    = prod[14:10];
        n_c.len    = len;
        n_c.octave = i_loc.octave;
        n_c.root   = i_loc.root;
        n_c.sel    = i_loc.sel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else begin
            r_c_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c <= n_c;
    end

    // stage d: remainder gives the table index, quotient minus bias moves the octave
    always_comb begin
        rem        = r_c.total - 7'(r_c.len) * 7'(r_c.quo);
        n_d.idx    = rem[2:0];
        n_d.octave = $signed(6'(r_c.octave) + 6'({1'b0, r_c.quo}) - 6'd8);
        n_d.root   = r_c.root;
        n_d.sel    = r_c.sel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else begin
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d <= n_d;
    end

    assign o_valid = r_d_valid;
    assign o_wrap  = r_d;

`ifndef SYNTHESIS
    a_index_in_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_d_valid |-> r_d.idx < sdt_pkg::SCALE_LEN[r_d.sel])
        else $error("wrapped index beyond scale length");
`endif

endmodule

// ----- src/sdt_rebuild.sv -----
`timescale 1ns / 1ps
module sdt_rebuild (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  sdt_pkg::t_wrap                    i_wrap,
    output logic                              o_valid,
    output logic signed [sdt_pkg::OUT_W-1:0]  o_note
);

    logic                             r_valid;
    logic signed [sdt_pkg::OUT_W-1:0] r_note;
    logic [9:0]                       oct_ext;
    logic [9:0]                       res;

    // root + 12 * octave + interval, two's complement
    always_comb begin
        oct_ext = {{4{i_wrap.octave[5]}}, i_wrap.octave};
        res = {6'b0, i_wrap.root} + oct_ext * 10'd12
            + {6'b0, sdt_pkg::scale_iv(i_wrap.sel, i_wrap.idx)};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_note <= $signed(res[8:0]);
    end

    assign o_valid = r_valid;
    assign o_note  = r_note;

endmodule

// ----- src/scale_degree_transposer_unit.sv -----
`timescale 1ns / 1ps
// an accepted item passes the registers of stages a, b, c, d and e before o_valid is raised
// throughput: one item per cycle, five register stages, busy is never raised
// the receiver cannot stall; results stream out one cycle each with o_valid
// reset (synchronous, active low) clears all stage valid bits and sets
// root 0 and scale type 0 (c major)
module scale_degree_transposer_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // command side
    input  logic                               start,
    output logic                               busy,
    input  logic [sdt_pkg::NOTE_W-1:0]         i_note_in,
    input  logic signed [sdt_pkg::SHIFT_W-1:0] i_degree_shift,
    // result side
    output logic                               o_valid,
    output logic signed [sdt_pkg::OUT_W-1:0]   o_note_out,
    // configuration write port
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_idx,
    input  logic [sdt_pkg::NOTE_W-1:0]         i_cfg_data
);

    logic           accept;
    sdt_pkg::t_pc   root;
    sdt_pkg::t_sel  sel;
    logic           loc_valid;
    sdt_pkg::t_loc  loc;
    logic           wrap_valid;
    sdt_pkg::t_wrap wrap;

    // fully pipelined, so an item is taken on every start
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // key registers: root pitch class and table select
    sdt_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_root     (root),
        .o_sel      (sel)
    );

    // stages a and b: octave / pitch class split, then nearest degree
    sdt_locate u_locate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_note  (i_note_in),
        .i_shift (i_degree_shift),
        .i_root  (root),
        .i_sel   (sel),
        .o_valid (loc_valid),
        .o_loc   (loc)
    );

    // stages c and d: add degree shift, floor wrap over scale length
    sdt_wrap u_wrap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (loc_valid),
        .i_loc   (loc),
        .o_valid (wrap_valid),
        .o_wrap  (wrap)
    );

    // stage e: rebuild the note into the output register
    sdt_rebuild u_rebuild (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (wrap_valid),
        .i_wrap  (wrap),
        .o_valid (o_valid),
        .o_note  (o_note_out)
    );

`ifndef SYNTHESIS
    a_fixed_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##5 o_valid)
        else $error("accepted item did not come out after five cycles");

    a_no_spurious_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && $past(i_rst_n, 5) |-> $past(accept, 5))
        else $error("result without a matching item");
`endif

endmodule

// ----- dv/tb_scale_degree_transposer_unit.sv -----
`timescale 1ns / 1ps
module tb_scale_degree_transposer_unit;

    // ---------------------------------------------------------------
    // transposed-note scoreboard: own copy of the key registers, a
    // predictor of the transposition and a queue of expected notes
    // ---------------------------------------------------------------
    class transposed_note_board;
        logic [sdt_pkg::NOTE_W-1:0]        root_reg;
        logic [sdt_pkg::TYPE_W-1:0]        type_reg;
        logic signed [sdt_pkg::OUT_W-1:0]  expected_notes[$];
        int                                mismatch_count;
        int                                checked_count;
        int                                steps[12][7];
        int                                steps_len[12];

        function new();
            root_reg       = '0;
            type_reg       = '0;
            mismatch_count = 0;
            checked_count  = 0;
            // interval tables in select-code order, unused slots zero
            steps = '{
                '{0, 2, 4, 5, 7, 9, 11},
                '{0, 2, 3, 5, 7, 8, 10},
                '{0, 2, 3, 5, 7, 8, 11},
                '{0, 2, 3, 5, 7, 9, 11},
                '{0, 2, 3, 5, 7, 9, 10},
                '{0, 1, 3, 5, 7, 8, 10},
                '{0, 2, 4, 6, 7, 9, 11},
                '{0, 2, 4, 5, 7, 9, 10},
                '{0, 1, 3, 5, 6, 8, 10},
                '{0, 2, 4, 7, 9, 0, 0},
                '{0, 3, 5, 7, 10, 0, 0},
                '{0, 3, 5, 6, 7, 10, 0}
            };
            steps_len = '{7, 7, 7, 7, 7, 7, 7, 7, 7, 5, 5, 6};
        endfunction

        function void write_reg(logic idx, logic [sdt_pkg::NOTE_W-1:0] data);
            if (idx == sdt_pkg::CFG_ROOT)
                root_reg = data;
            else
                type_reg = data[sdt_pkg::TYPE_W-1:0];
        endfunction

        function int div_down(int a, int b);
            int q;
            q = a / b;
            if ((a % b) != 0 && a < 0)
                q = q - 1;
            return q;
        endfunction

        function int semitone_gap(int a, int b);
            return (a > b) ? a - b : b - a;
        endfunction

        function logic signed [sdt_pkg::OUT_W-1:0] transpose(
                logic [sdt_pkg::NOTE_W-1:0] note,
                logic signed [sdt_pkg::SHIFT_W-1:0] shift);
            int sel, len, key, octave, rel, degree, total, wrap, res;
            // codes 12..15 fall back to major
            sel    = (type_reg < 12) ? int'(type_reg) : 0;
            len    = steps_len[sel];
            key    = int'(root_reg) % 12;
            octave = div_down(int'(note) - key, 12);
            rel    = int'(note) - key - 12 * octave;
            // nearest degree, plain distance, lower index wins a tie
            degree = 0;
            for (int i = 1; i < len; i++) begin
                if (semitone_gap(steps[sel][i], rel) < semitone_gap(steps[sel][degree], rel))
                    degree = i;
            end
            total  = degree + int'(shift);
            wrap   = div_down(total, len);
            octave = octave + wrap;
            total  = total - len * wrap;
            res    = key + 12 * octave + steps[sel][total];
            return res[sdt_pkg::OUT_W-1:0];
        endfunction

        function void note_accepted(logic [sdt_pkg::NOTE_W-1:0] note,
                                    logic signed [sdt_pkg::SHIFT_W-1:0] shift);
            expected_notes.push_back(transpose(note, shift));
        endfunction

        function void check_note_out(logic signed [sdt_pkg::OUT_W-1:0] actual);
            logic signed [sdt_pkg::OUT_W-1:0] want;
            if (expected_notes.size() == 0) begin
                $error("note_out: no item pending, got %0d", actual);
                mismatch_count++;
            end else begin
                want = expected_notes.pop_front();
                checked_count++;
                if (actual !== want) begin
                    $error("note_out: expected %0d, actual %0d", want, actual);
                    mismatch_count++;
                end
            end
        endfunction

        function int pending();
            return expected_notes.size();
        endfunction
    endclass

    // ---------------------------------------------------------------
    // clock, reset and block ports
    // ---------------------------------------------------------------
    logic                               i_clk;
    logic                               i_rst_n;
    logic                               start;
    logic                               busy;
    logic [sdt_pkg::NOTE_W-1:0]         i_note_in;
    logic signed [sdt_pkg::SHIFT_W-1:0] i_degree_shift;
    logic                               o_valid;
    logic signed [sdt_pkg::OUT_W-1:0]   o_note_out;
    logic                               i_cfg_we;
    logic                               i_cfg_idx;
    logic [sdt_pkg::NOTE_W-1:0]         i_cfg_data;

    transposed_note_board board = new();
    int key_settings = 0;

    scale_degree_transposer_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_note_in      (i_note_in),
        .i_degree_shift (i_degree_shift),
        .o_valid        (o_valid),
        .o_note_out     (o_note_out),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    // 12 ns period
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // result side: every strobe is one transposed note, no back-pressure
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            board.check_note_out(o_note_out);
    end

    // ---------------------------------------------------------------
    // driving tasks, all inputs change on the falling edge
    // ---------------------------------------------------------------

    // one item: optional idle gap, then hold start until busy is low at an edge
    task automatic send_item(input logic [sdt_pkg::NOTE_W-1:0] note,
                             input logic signed [sdt_pkg::SHIFT_W-1:0] shift,
                             input int gap);
        logic taken;
        taken = 1'b0;
        repeat (gap) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start          <= 1'b1;
        i_note_in      <= note;
        i_degree_shift <= shift;
        while (!taken) begin
            @(posedge i_clk);
            taken = !busy;
        end
        board.note_accepted(note, shift);
    endtask

    // register write, only called with the pipe empty
    task automatic write_reg(input logic idx, input logic [sdt_pkg::NOTE_W-1:0] data);
        @(negedge i_clk);
        start      <= 1'b0;
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        board.write_reg(idx, data);
    endtask

    // stop sending, wait for every pending note, then let the five-stage pipe settle
    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (board.pending() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_key(input logic [sdt_pkg::NOTE_W-1:0] root,
                           input logic [sdt_pkg::NOTE_W-1:0] scale);
        drain();
        if ($urandom_range(0, 1)) begin
            write_reg(sdt_pkg::CFG_ROOT, root);
            write_reg(sdt_pkg::CFG_SCALE, scale);
        end else begin
            write_reg(sdt_pkg::CFG_SCALE, scale);
            write_reg(sdt_pkg::CFG_ROOT, root);
        end
        key_settings++;
    endtask

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------
    initial begin
        logic [sdt_pkg::NOTE_W-1:0]         note;
        logic signed [sdt_pkg::SHIFT_W-1:0] shift;
        logic [sdt_pkg::NOTE_W-1:0]         root;
        int                                 gap;

        // every input known from time zero
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_note_in      = '0;
        i_degree_shift = '0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = sdt_pkg::CFG_ROOT;
        i_cfg_data     = '0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: reset key is c major
        key_settings = 1;
        send_item(7'd0,   6'sd0,   0);
        send_item(7'd127, 6'sd0,   0);
        send_item(7'd0,  -6'sd16,  1);
        send_item(7'd127, 6'sd16,  0);
        send_item(7'd127, 6'sd31,  2);   // shift beyond the usual range
        send_item(7'd0,  -6'sd32,  0);
        send_item(7'd1,   6'sd0,   0);   // tie between degrees 0 and 1
        send_item(7'd6,   6'sd1,   3);   // tie between fa and sol
        send_item(7'd11, -6'sd1,   0);
        send_item(7'd12,  6'sd7,   0);   // one full octave of degrees
        send_item(7'd60, -6'sd7,   1);

        // root 127 is pitch class 7, type 15 falls back to major
        set_key(7'd127, 7'd15);
        send_item(7'd0,   6'sd0,   0);   // note below the root, negative octave
        send_item(7'd127, -6'sd32, 0);
        send_item(7'd6,   6'sd16,  2);

        // blues minor on root 11
        set_key(7'd11, 7'd11);
        send_item(7'd0,   6'sd0,   0);
        send_item(7'd127, 6'sd31,  0);
        send_item(7'd10, -6'sd1,   1);
        send_item(7'd5,   6'sd2,   0);

        // major pentatonic: rel 11 snaps to 9, no wrap to the next root
        set_key(7'd0, 7'd9);
        send_item(7'd11,  6'sd0,   0);
        send_item(7'd127, -6'sd16, 0);
        send_item(7'd0,   6'sd31,  4);

        // random: one phase per scale code, extremes of root at the ends,
        // unused high bits of the type write set at random
        for (int p = 0; p < 16; p++) begin
            root = (p == 0) ? 7'd0 : (p == 15) ? 7'd127 : 7'($urandom_range(0, 127));
            set_key(root, {3'($urandom_range(0, 7)), 4'(p)});
            for (int i = 0; i < 70; i++) begin
                note = 7'($urandom_range(0, 127));
                // mostly the nominal +-16 range, sometimes the full port range
                if ($urandom_range(0, 4) == 0)
                    shift = 6'($urandom_range(0, 63));
                else
                    shift = 6'($urandom_range(0, 32) - 16);
                // back-to-back bursts alternate with random idle gaps
                gap = ((i % 40) < 15) ? 0 : $urandom_range(0, 5);
                send_item(note, shift, gap);
            end
        end

        @(negedge i_clk);
        start <= 1'b0;
        drain();

        $display("transposed %0d notes across %0d key settings covering all 16 scale codes",
                 board.checked_count, key_settings);
        if (board.mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // hang guard, far beyond the slowest correct run
    initial begin
        #2_400_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
